/* sv/xtte_pkg.sv */
package xtte_pkg;

    // default capacity of the tag store in bytes
    localparam int TAG_BYTES_DEF = 32;

    // the longest tag name that is ever matched, "</title"
    localparam int PFX_BYTES = 7;
    localparam int PFX_W     = PFX_BYTES * 8;

    // word widths on the stream ports
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    // event codes
    localparam logic [1:0] EV_BEGIN = 2'd0;
    localparam logic [1:0] EV_BYTE  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    // field kinds
    localparam logic KIND_TITLE = 1'b0;
    localparam logic KIND_TEXT  = 1'b1;

    // markup characters
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;

    // tag names, first character in the top byte
    localparam logic [39:0] PAT_PAGE   = "<page";
    localparam logic [39:0] PAT_TEXT   = "<text";
    localparam logic [47:0] PAT_TITLE  = "<title";
    localparam logic [47:0] PAT_EPAGE  = "</page";
    localparam logic [47:0] PAT_ETEXT  = "</text";
    localparam logic [55:0] PAT_ETITLE = "</title";

endpackage

/* sv/xml_title_text_extractor.sv */
// output: a word shows the cycle after its byte is taken; flushed bytes pass rd_data_reg first
// throughput: one byte per cycle while m_tready stays high; a '<' that cuts a held tag
//   short inside a field flushes that tag, one word per cycle from the tag memory while
//   m_tready stays high, at most TAG_BYTES words, and no new byte is taken until it ends
// reset: synchronous on aresetn low; parse state, tag length, overflow flag and the
//   output valid clear, the tag memory is not cleared (only written entries are read)
module xml_title_text_extractor #(
    parameter int TAG_BYTES = xtte_pkg::TAG_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [xtte_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [xtte_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [8] tag_overflow
    output logic [xtte_pkg::M_TUSER_W-1:0]  m_tuser,   // [1:0] event_res, [2] field_kind
    output logic                            m_tlast    // run_last
);
    import xtte_pkg::*;

    localparam int LEN_W = $clog2(TAG_BYTES + 1);
    localparam int IDX_W = $clog2(TAG_BYTES);

    // parse state of the stream
    typedef enum logic [2:0] {
        PS_NORMAL    = 3'd0,
        PS_PAGE      = 3'd1,
        PS_TITLE     = 3'd2,
        PS_TEXT      = 3'd3,
        PS_TITLE_TAG = 3'd4,
        PS_TEXT_TAG  = 3'd5
    } parse_t;

    // sequencer: taking bytes, or flushing a held tag from memory
    typedef enum logic {
        CTL_IDLE  = 1'b0,
        CTL_FLUSH = 1'b1
    } ctl_t;

    // tag memory, one synchronous write port and one registered read port
    logic [7:0]       tag_mem [TAG_BYTES];
    logic [7:0]       rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    parse_t           parse_reg, parse_next;
    ctl_t             ctl_reg, ctl_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    // shadow of the first tag bytes for name matching, byte 0 on top
    logic [PFX_W-1:0] pfx_reg, pfx_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_event_reg, out_event_next;
    logic             out_kind_reg, out_kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_ovf_reg, out_ovf_next;
    logic             out_last_reg, out_last_next;

    logic             out_free;
    logic             s_accept;
    logic [7:0]       in_b;
    logic             flush_last;

    // tag name matches on the held bytes
    logic is_page, is_text, is_text_attr, is_title, is_epage, is_etext, is_etitle;

    assign in_b     = s_tdata[7:0];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (ctl_reg == CTL_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign is_page      = (len_reg == LEN_W'(5)) && (pfx_reg[PFX_W-1 -: 40] == PAT_PAGE);
    assign is_text      = (len_reg == LEN_W'(5)) && (pfx_reg[PFX_W-1 -: 40] == PAT_TEXT);
    // text tag carrying attributes
    assign is_text_attr = (len_reg > LEN_W'(7)) && (pfx_reg[PFX_W-1 -: 40] == PAT_TEXT);
    assign is_title     = (len_reg == LEN_W'(6)) && (pfx_reg[PFX_W-1 -: 48] == PAT_TITLE);
    assign is_epage     = (len_reg == LEN_W'(6)) && (pfx_reg[PFX_W-1 -: 48] == PAT_EPAGE);
    assign is_etext     = (len_reg == LEN_W'(6)) && (pfx_reg[PFX_W-1 -: 48] == PAT_ETEXT);
    assign is_etitle    = (len_reg == LEN_W'(7)) && (pfx_reg == PAT_ETITLE);

    // last byte of the flush when the next index reaches the held length
    assign flush_last = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;

    always_comb begin
        parse_next     = parse_reg;
        ctl_next       = ctl_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        pfx_next       = pfx_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_event_next = out_event_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = in_b;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (ctl_reg)
            CTL_IDLE: begin
                if (s_accept) begin
                    unique case (parse_reg)
                        PS_TITLE, PS_TEXT: begin
                            if (in_b == CH_LT) begin
                                // open a tag inside the field
                                len_next  = LEN_W'(1);
                                ovf_next  = 1'b0;
                                mem_we    = 1'b1;
                                mem_wdata = CH_LT;
                                pfx_next[PFX_W-1 -: 8] = CH_LT;
                                parse_next = (parse_reg == PS_TITLE) ? PS_TITLE_TAG
                                                                     : PS_TEXT_TAG;
                            end else begin
                                out_valid_next = 1'b1;
                                out_event_next = EV_BYTE;
                                out_kind_next  = (parse_reg == PS_TEXT) ? KIND_TEXT
                                                                        : KIND_TITLE;
                                out_byte_next  = in_b;
                                out_ovf_next   = 1'b0;
                                out_last_next  = 1'b1;
                            end
                        end
                        PS_TITLE_TAG, PS_TEXT_TAG: begin
                            if (in_b == CH_GT) begin
                                if ((parse_reg == PS_TEXT_TAG) ? is_etext : is_etitle) begin
                                    out_valid_next = 1'b1;
                                    out_event_next = EV_END;
                                    out_kind_next  = (parse_reg == PS_TEXT_TAG) ? KIND_TEXT
                                                                                : KIND_TITLE;
                                    out_byte_next  = '0;
                                    out_ovf_next   = 1'b0;
                                    out_last_next  = 1'b1;
                                    parse_next     = PS_PAGE;
                                end else begin
                                    // unknown tag inside a field is dropped
                                    parse_next = (parse_reg == PS_TEXT_TAG) ? PS_TEXT
                                                                            : PS_TITLE;
                                end
                            end else if (in_b == CH_LT) begin
                                // flush the held tag as content, entry 0 first
                                ctl_next  = CTL_FLUSH;
                                idx_next  = '0;
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                            end else begin
                                if (len_reg < LEN_W'(TAG_BYTES)) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = len_reg[IDX_W-1:0];
                                    len_next  = len_reg + LEN_W'(1);
                                    for (int k = 0; k < PFX_BYTES; k++) begin
                                        if (len_reg == LEN_W'(k)) begin
                                            pfx_next[PFX_W-1-8*k -: 8] = in_b;
                                        end
                                    end
                                end else begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // outside a field; unused codes behave as normal
                            if (in_b == CH_LT) begin
                                len_next  = LEN_W'(1);
                                ovf_next  = 1'b0;
                                mem_we    = 1'b1;
                                mem_wdata = CH_LT;
                                pfx_next[PFX_W-1 -: 8] = CH_LT;
                            end else if (in_b == CH_GT) begin
                                priority if (is_page) begin
                                    parse_next = PS_PAGE;
                                end else if (is_text || is_text_attr) begin
                                    parse_next     = PS_TEXT;
                                    out_valid_next = 1'b1;
                                    out_event_next = EV_BEGIN;
                                    out_kind_next  = KIND_TEXT;
                                    out_byte_next  = '0;
                                    out_ovf_next   = 1'b0;
                                    out_last_next  = 1'b1;
                                end else if (is_title) begin
                                    parse_next     = PS_TITLE;
                                    out_valid_next = 1'b1;
                                    out_event_next = EV_BEGIN;
                                    out_kind_next  = KIND_TITLE;
                                    out_byte_next  = '0;
                                    out_ovf_next   = 1'b0;
                                    out_last_next  = 1'b1;
                                end else if (is_epage) begin
                                    parse_next = PS_NORMAL;
                                end else if (is_etext || is_etitle) begin
                                    parse_next = PS_PAGE;
                                end else begin
                                    parse_next = PS_NORMAL;
                                end
                            end else begin
                                if (len_reg < LEN_W'(TAG_BYTES)) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = len_reg[IDX_W-1:0];
                                    len_next  = len_reg + LEN_W'(1);
                                    for (int k = 0; k < PFX_BYTES; k++) begin
                                        if (len_reg == LEN_W'(k)) begin
                                            pfx_next[PFX_W-1-8*k -: 8] = in_b;
                                        end
                                    end
                                end else begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            CTL_FLUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_event_next = EV_BYTE;
                    out_kind_next  = (parse_reg == PS_TEXT_TAG) ? KIND_TEXT : KIND_TITLE;
                    out_byte_next  = rd_data_reg;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = flush_last;
                    if (flush_last) begin
                        // every entry has been read, reopen the tag with '<'
                        ctl_next  = CTL_IDLE;
                        len_next  = LEN_W'(1);
                        ovf_next  = 1'b0;
                        mem_we    = 1'b1;
                        mem_wdata = CH_LT;
                        pfx_next[PFX_W-1 -: 8] = CH_LT;
                    end else begin
                        idx_next  = idx_reg + IDX_W'(1);
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_reg     <= PS_NORMAL;
            ctl_reg       <= CTL_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            parse_reg     <= parse_next;
            ctl_reg       <= ctl_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
        // payload registers carry no reset
        pfx_reg       <= pfx_next;
        out_event_reg <= out_event_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= tag_mem[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 9)'(0), out_ovf_reg, out_byte_reg};
    assign m_tuser  = {out_kind_reg, out_event_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* sv/xtte_checker.sv */
module xtte_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [xtte_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [xtte_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [xtte_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            m_tlast
);
    import xtte_pkg::*;

    // no word left over from before reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result word changed");

    // a blocked output also blocks the input side
    a_in_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    // begin and end words are single, carry no byte and no overflow
    a_marker_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == EV_BEGIN || m_tuser[1:0] == EV_END)
        |-> m_tlast && (m_tdata == '0))
        else $error("malformed begin or end word");

    // only the three known events appear
    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == EV_BEGIN || m_tuser[1:0] == EV_BYTE
                      || m_tuser[1:0] == EV_END))
        else $error("unknown event code");

endmodule

bind xml_title_text_extractor xtte_checker u_xtte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
